/* sv/sds_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// SCAN disk scheduler package
// Shared widths, configuration register codes and interface structs.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int CYL_W        = 16;
  localparam int SEEK_W       = 18;
  localparam int DISK_W       = 17;
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int IDX_W        = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int RUN_W        = $clog2(MAX_REQUESTS + 2);

  localparam int IN_TDATA_W   = ((CYL_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((CYL_W + SEEK_W + 7) / 8) * 8;

  // Request queue between the front and the back; depth is a power of two.
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DISK_W;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISK_CYL   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP   = 2'd2;

  typedef struct packed {
    logic [CYL_W-1:0] cylinder;
    logic             last;
  } req_t;

  typedef struct packed {
    logic             ins_en;
    logic [CYL_W-1:0] ins_cyl;
    logic             clear;
    logic [IDX_W-1:0] rd_addr;
  } store_ctl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             overflow;
  } store_sts_t;

endpackage
`default_nettype wire

/* sv/sds_req_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// SCAN disk scheduler request queue
// Front end: accepts request transactions, unpacks them and buffers them.
// ----------------------------------------------------------------------------
module sds_req_queue
  import sds_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,   // [15:0] cylinder
  input  wire logic                  in_tlast,   // last_request
  output logic                       q_valid,
  input  wire logic                  q_pop,
  output req_t                       q_req
);

  req_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] used_r, used_nxt;
  logic              push, pop;

  assign in_tready = (used_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid   = (used_r != '0);
  assign q_req     = mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    used_nxt   = used_r;
    if (push && !pop) begin
      used_nxt = used_r + 1'b1;
    end else if (pop && !push) begin
      used_nxt = used_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{cylinder: in_tdata[CYL_W-1:0], last: in_tlast};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      used_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      used_r   <= used_nxt;
    end
  end

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("request queue occupancy above its depth");
`endif

endmodule
`default_nettype wire

/* sv/sds_sort_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// SCAN disk scheduler sorted store
// Row of insertion cells that keeps the batch in ascending order.
// ----------------------------------------------------------------------------
module sds_sort_store
  import sds_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire store_ctl_t       ctl,
  output store_sts_t            sts,
  output logic [CYL_W-1:0]      rd_data
);

  logic [CYL_W-1:0]        store_r   [MAX_REQUESTS];
  logic [CYL_W-1:0]        store_nxt [MAX_REQUESTS];
  logic [MAX_REQUESTS-1:0] gt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    room;

  assign room    = (count_r < CNT_W'(MAX_REQUESTS));
  assign rd_data = store_r[ctl.rd_addr];
  assign sts     = '{count: count_r, overflow: ovf_r};

  // Each cell compares its entry with the new request. A cell whose lower neighbor
  // holds a larger value takes that neighbor's entry; else the first larger cell,
  // or the cell at the fill count if none is larger, takes the request.
  always_comb begin
    for (int k = 0; k < MAX_REQUESTS; k++) begin
      gt[k] = (CNT_W'(k) < count_r) && (store_r[k] > ctl.ins_cyl);
    end
    for (int k = 0; k < MAX_REQUESTS; k++) begin
      if (k > 0 && gt[(k > 0) ? k - 1 : 0]) begin
        store_nxt[k] = store_r[(k > 0) ? k - 1 : 0];
      end else if (gt[k] || CNT_W'(k) == count_r) begin
        store_nxt[k] = ctl.ins_cyl;
      end else begin
        store_nxt[k] = store_r[k];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (ctl.clear) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (ctl.ins_en) begin
      if (room) begin
        count_nxt = count_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ins_en && room) begin
      store_r <= store_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_REQUESTS))
    else $error("sorted store fill count above capacity");
`endif

endmodule
`default_nettype wire

/* sv/sds_service.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// SCAN disk scheduler service sequencer
// Back end: loads requests, finds the sweep split and emits the visit order.
// ----------------------------------------------------------------------------
module sds_service
  import sds_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  input  wire req_t                   q_req,
  output logic                        q_pop,
  output store_ctl_t                  ctl,
  input  wire store_sts_t             sts,
  input  wire logic [CYL_W-1:0]       rd_data,
  input  wire logic [CYL_W-1:0]       start_head,
  input  wire logic [CYL_W-1:0]       far_end,
  input  wire logic                   sweep_up,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast,
  output logic                        out_tuser
);

  typedef enum logic [1:0] {ST_LOAD, ST_PREP, ST_SEARCH, ST_SERVE} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CNT_W-1:0]  split_r, split_nxt, idx_r, idx_nxt;
  logic              phase_b_r, phase_b_nxt;
  logic [RUN_W-1:0]  remain_r, remain_nxt;
  logic [CYL_W-1:0]  head_r, head_nxt;
  logic [SEEK_W-1:0] seek_r, seek_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CYL_W-1:0]  out_pos_r, out_pos_nxt;
  logic [SEEK_W-1:0] out_seek_r, out_seek_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_drop_r, out_drop_nxt;

  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  mid, idx_dec;
  logic              asc, has, walk, slot_free;
  logic [CYL_W-1:0]  emit_pos, move_len;
  logic [SEEK_W:0]   seek_sum;

  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid       = mid_sum[CNT_W:1];
  assign idx_dec   = idx_r - 1'b1;
  // Ascending walks: the first leg when sweeping up, the second when down.
  assign asc       = phase_b_r ^ sweep_up;
  assign has       = asc ? (idx_r < sts.count) : (idx_r != '0);
  assign walk      = phase_b_r || has;
  assign emit_pos  = walk ? rd_data : (sweep_up ? far_end : '0);
  assign move_len  = (emit_pos > head_r) ? emit_pos - head_r : head_r - emit_pos;
  assign seek_sum  = {1'b0, seek_r} + (SEEK_W + 1)'(move_len);
  assign slot_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_seek_r, out_pos_r});
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_drop_r;

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    split_nxt     = split_r;
    idx_nxt       = idx_r;
    phase_b_nxt   = phase_b_r;
    remain_nxt    = remain_r;
    head_nxt      = head_r;
    seek_nxt      = seek_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pos_nxt   = out_pos_r;
    out_seek_nxt  = out_seek_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;
    q_pop         = 1'b0;
    ctl           = '{ins_en: 1'b0, ins_cyl: q_req.cylinder, clear: 1'b0,
                      rd_addr: '0};

    unique case (state_r)
      ST_LOAD: begin
        q_pop      = q_valid;
        ctl.ins_en = q_valid;
        if (q_valid && q_req.last) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        lo_nxt    = '0;
        hi_nxt    = sts.count;
        state_nxt = ST_SEARCH;
      end
      ST_SEARCH: begin
        // Binary search for the first entry strictly above the head.
        ctl.rd_addr = mid[IDX_W-1:0];
        if (lo_r < hi_r) begin
          if (rd_data > start_head) begin
            hi_nxt = mid;
          end else begin
            lo_nxt = mid + 1'b1;
          end
        end else begin
          split_nxt   = lo_r;
          idx_nxt     = lo_r;
          phase_b_nxt = 1'b0;
          remain_nxt  = RUN_W'(sts.count) + 1'b1;
          head_nxt    = start_head;
          seek_nxt    = '0;
          state_nxt   = ST_SERVE;
        end
      end
      ST_SERVE: begin
        ctl.rd_addr = asc ? idx_r[IDX_W-1:0] : idx_dec[IDX_W-1:0];
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = emit_pos;
          seek_nxt      = (seek_sum > (SEEK_W + 1)'(SEEK_MAX)) ? SEEK_MAX
                                                              : seek_sum[SEEK_W-1:0];
          out_seek_nxt  = seek_nxt;
          out_last_nxt  = (remain_r == RUN_W'(1));
          out_drop_nxt  = sts.overflow;
          head_nxt      = emit_pos;
          remain_nxt    = remain_r - 1'b1;
          if (walk) begin
            idx_nxt = asc ? idx_r + 1'b1 : idx_dec;
          end else begin
            phase_b_nxt = 1'b1;
            idx_nxt     = split_r;
          end
          if (remain_r == RUN_W'(1)) begin
            ctl.clear = 1'b1;
            state_nxt = ST_LOAD;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    split_r    <= split_nxt;
    idx_r      <= idx_nxt;
    phase_b_r  <= phase_b_nxt;
    remain_r   <= remain_nxt;
    head_r     <= head_nxt;
    seek_r     <= seek_nxt;
    out_pos_r  <= out_pos_nxt;
    out_seek_r <= out_seek_nxt;
    out_last_r <= out_last_nxt;
    out_drop_r <= out_drop_nxt;
  end

`ifndef SYNTHESIS
  a_search_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEARCH) |-> (lo_r <= hi_r))
    else $error("split search bounds crossed");
  a_emit_in_serve: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && !(out_valid_r && !out_tready)) |-> (state_r == ST_SERVE))
    else $error("result issued outside service");
`endif

endmodule
`default_nettype wire

/* sv/scan_disk_scheduler_unit.sv */
`default_nettype none
// Loading: one request per cycle while the queue has room; each request enters the insertion row.
// Service: after the last request, a prep state and a binary split search of the sorted store,
// then count+1 results at one per cycle through the output register while out_tready allows.
// Throughput of the service is set by the single read port of the sorted store.
// Reset (rst_n, synchronous, active low) empties the batch and the queue and restores
// start_head = 0, disk_cylinders = 65536 and sweep_up_first = 1; store contents are not cleared.
// ----------------------------------------------------------------------------
// SCAN disk scheduler
// Sorts a batch of cylinder requests and serves it in elevator order.
// ----------------------------------------------------------------------------
module scan_disk_scheduler_unit
  import sds_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Request channel.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] cylinder
  input  wire logic                   in_tlast,   // last_request
  // Result channel.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [15:0] position, [33:16] seek_total
  output logic                        out_tlast,  // end_of_run
  output logic                        out_tuser,  // dropped
  // Configuration write channel.
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [CYL_W-1:0]  start_head_r, start_head_nxt;
  logic [DISK_W-1:0] disk_cyl_r, disk_cyl_nxt;
  logic              sweep_up_r, sweep_up_nxt;
  logic [CYL_W-1:0]  far_end;
  logic              cfg_write;

  logic       q_valid, q_pop;
  req_t       q_req;
  store_ctl_t ctl;
  store_sts_t sts;
  logic [CYL_W-1:0] rd_data;

  // Configuration is always accepted; an index past the list is ignored.
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  always_comb begin
    start_head_nxt = start_head_r;
    disk_cyl_nxt   = disk_cyl_r;
    sweep_up_nxt   = sweep_up_r;
    if (cfg_write) begin
      unique case (cfg_index)
        CFG_START_HEAD: start_head_nxt = cfg_data[CYL_W-1:0];
        CFG_DISK_CYL:   disk_cyl_nxt   = cfg_data[DISK_W-1:0];
        CFG_SWEEP_UP:   sweep_up_nxt   = cfg_data[0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_head_r <= '0;
      disk_cyl_r   <= DISK_W'(1) << CYL_W;
      sweep_up_r   <= 1'b1;
    end else begin
      start_head_r <= start_head_nxt;
      disk_cyl_r   <= disk_cyl_nxt;
      sweep_up_r   <= sweep_up_nxt;
    end
  end

  // The far end is one below the cylinder count; a count of zero turns at
  // cylinder zero, and a count past the position range turns at its top.
  always_comb begin
    if (disk_cyl_r == '0) begin
      far_end = '0;
    end else if (disk_cyl_r[DISK_W-1]) begin
      far_end = '1;
    end else begin
      far_end = disk_cyl_r[CYL_W-1:0] - 1'b1;
    end
  end

  // Front end: request queue.
  sds_req_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_req     (q_req)
  );

  // Sorted batch of requests.
  sds_sort_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .sts     (sts),
    .rd_data (rd_data)
  );

  // Back end: loading, split search and the elevator walk.
  sds_service u_service (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_req      (q_req),
    .q_pop      (q_pop),
    .ctl        (ctl),
    .sts        (sts),
    .rd_data    (rd_data),
    .start_head (start_head_r),
    .far_end    (far_end),
    .sweep_up   (sweep_up_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
